### rtl/core/mfs_pkg.sv
package mfs_pkg;

  // Character codes
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChQm    = 8'h3F;

  // Separator codes
  localparam logic [2:0] SepNone     = 3'd0;
  localparam logic [2:0] SepComma    = 3'd1;
  localparam logic [2:0] SepSlash    = 3'd2;
  localparam logic [2:0] SepNewline  = 3'd3;
  localparam logic [2:0] SepEquals   = 3'd4;
  localparam logic [2:0] SepQuestion = 3'd5;

  // Saturation limits
  localparam logic [15:0] PosMax  = 16'hFFFF;
  localparam logic [15:0] LineMax = 16'hFFFF;

  // Tracking state of the message in progress
  typedef struct packed {
    logic [15:0] byte_index;
    logic [16:0] field_begin;
    logic [15:0] line_number;
    logic [2:0]  last_separator;
    logic        escape_pending;
  } state_t;

  // One field descriptor plus its framing flags
  typedef struct packed {
    logic [15:0] field_line;
    logic [2:0]  field_separator;
    logic [15:0] field_start;
    logic [15:0] field_length;
    logic        run_last;
    logic        message_done;
  } result_t;

  // Decoder outputs for one byte
  typedef struct packed {
    result_t     res0;
    result_t     res1;
    logic [1:0]  count;
    state_t      next;
  } decode_t;

  // Build a descriptor for a field that ends before end_pos
  function automatic result_t make_field(logic [15:0] line, logic [2:0] sep,
                                         logic [16:0] begin_pos, logic [16:0] end_pos);
    result_t     r;
    logic [16:0] diff;
    r = '0;
    diff = end_pos - begin_pos;
    r.field_line      = line;
    r.field_separator = sep;
    r.field_start     = begin_pos[16] ? 16'hFFFF : begin_pos[15:0];
    if (end_pos > begin_pos) begin
      r.field_length = diff[16] ? 16'hFFFF : diff[15:0];
    end else begin
      r.field_length = 16'd0;
    end
    return r;
  endfunction

endpackage

### rtl/core/message_field_splitter_unit.sv
// Channel   | Dir | Signals                       | Contents
// s_axis    | in  | tvalid tready tdata[7:0] tlast | data_byte; tlast = message_end
// m_axis    | out | tvalid tready tdata[55:0]      | field descriptor, see port list
//           |     | tlast tuser                   | tlast = run_last, tuser = message_done
// cfg       | in  | cfg_wr_en_i cfg_wr_data_i     | mask_mode
//
// One byte per cycle while each byte yields at most one field and m_axis accepts; a
// byte that closes two fields holds s_axis_tready low until its first descriptor has
// moved, since m_axis moves one descriptor per cycle from the two-entry result buffer.
// A descriptor is registered: m_axis_tvalid rises in the cycle after its input transfer.
// Reset clears the message state (line 1, offset 0) and mask_mode.
// A stall on m_axis lowers s_axis_tready once the buffer cannot be drained.
module message_field_splitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] field_line, [18:16] field_separator,
                                      // [34:19] field_start, [50:35] field_length
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // message_done
);

  logic             mask_mode_q;
  mfs_pkg::state_t  state_q;
  mfs_pkg::decode_t dec;
  mfs_pkg::result_t head;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_mode_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      mask_mode_q <= cfg_wr_data_i;
    end
  end

  // Message state advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.byte_index     <= 16'd0;
      state_q.field_begin    <= 17'd0;
      state_q.line_number    <= 16'd1;
      state_q.last_separator <= mfs_pkg::SepNone;
      state_q.escape_pending <= 1'b0;
    end else if (accept) begin
      state_q <= dec.next;
    end
  end

  mfs_field_decode u_decode (
    .data_byte_i   (s_axis_tdata),
    .message_end_i (s_axis_tlast),
    .mask_mode_i   (mask_mode_q),
    .state_i       (state_q),
    .dec_o         (dec)
  );

  mfs_out_buffer u_out_buffer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .res0_i    (dec.res0),
    .res1_i    (dec.res1),
    .count_i   (dec.count),
    .load_ok_o (s_axis_tready),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .head_o    (head)
  );

  // Pack the head descriptor
  assign m_axis_tdata = {5'd0, head.field_length, head.field_start,
                         head.field_separator, head.field_line};
  assign m_axis_tlast = head.run_last;
  assign m_axis_tuser = head.message_done;

  msg_end_clear_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (state_q.byte_index == 16'd0) &&
    (state_q.line_number == 16'd1) && !state_q.escape_pending)
    else $error("state not cleared at message end");
  begin_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.field_begin <= ({1'b0, state_q.byte_index} + 17'd1))
    else $error("field start beyond next offset");
  line_nonzero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line_number != 16'd0) else $error("line number zero");
  done_is_last_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("message end flag on a non-final result");

endmodule

### rtl/core/mfs_field_decode.sv
module mfs_field_decode (
  input  logic [7:0]      data_byte_i,
  input  logic            message_end_i,
  input  logic            mask_mode_i,
  input  mfs_pkg::state_t state_i,
  output mfs_pkg::decode_t dec_o
);

  logic               is_eq, is_qm, is_esc, is_slash, is_sep;
  logic               emit_a, emit_b, esc_at_end;
  logic [16:0]        idx_ext, idx_plus1, end_a;
  mfs_pkg::state_t    nxt;
  mfs_pkg::result_t   res_a, res_b;

  assign is_eq    = (data_byte_i == mfs_pkg::ChEq);
  assign is_qm    = (data_byte_i == mfs_pkg::ChQm);
  assign is_esc   = (data_byte_i == mfs_pkg::ChEsc);
  assign is_slash = (data_byte_i == mfs_pkg::ChSlash);
  assign is_sep   = (data_byte_i == mfs_pkg::ChComma) || is_slash ||
                    (data_byte_i == mfs_pkg::ChNl);
  assign idx_ext   = {1'b0, state_i.byte_index};
  assign idx_plus1 = idx_ext + 17'd1;

  // Classify the byte and update the field tracking
  always_comb begin
    nxt        = state_i;
    emit_a     = 1'b0;
    esc_at_end = 1'b0;
    end_a      = idx_ext;
    if (state_i.escape_pending) begin
      nxt.escape_pending = 1'b0;
      if (is_eq || is_qm) begin
        emit_a             = (state_i.byte_index > 16'd1);
        end_a              = idx_ext - 17'd1;
        nxt.last_separator = is_eq ? mfs_pkg::SepEquals : mfs_pkg::SepQuestion;
      end
      nxt.field_begin = idx_plus1;
    end else if (is_esc) begin
      if (message_end_i) begin
        esc_at_end = 1'b1;
      end else begin
        nxt.escape_pending = 1'b1;
      end
    end else if (!mask_mode_i && is_sep) begin
      emit_a = (state_i.byte_index != 16'd0);
      end_a  = idx_ext;
      if (data_byte_i == mfs_pkg::ChNl && state_i.line_number < mfs_pkg::LineMax) begin
        nxt.line_number = state_i.line_number + 16'd1;
      end
      nxt.field_begin = idx_plus1;
      if (data_byte_i == mfs_pkg::ChComma) begin
        nxt.last_separator = mfs_pkg::SepComma;
      end else if (is_slash) begin
        nxt.last_separator = mfs_pkg::SepSlash;
      end else begin
        nxt.last_separator = mfs_pkg::SepNewline;
      end
    end
  end

  // Flush the pending field on the last byte, or a null field if that byte is a slash
  assign emit_b = message_end_i && !esc_at_end &&
                  ((nxt.field_begin < idx_plus1) || is_slash);

  assign res_a = mfs_pkg::make_field(state_i.line_number, state_i.last_separator,
                                     state_i.field_begin, end_a);
  assign res_b = mfs_pkg::make_field(nxt.line_number, nxt.last_separator,
                                     nxt.field_begin, idx_plus1);

  // Order results and mark the last one of the byte and of the message
  always_comb begin
    dec_o      = '0;
    dec_o.next = nxt;
    if (emit_a) begin
      dec_o.res0  = res_a;
      dec_o.res1  = res_b;
      dec_o.count = emit_b ? 2'd2 : 2'd1;
    end else begin
      dec_o.res0  = res_b;
      dec_o.res1  = res_b;
      dec_o.count = emit_b ? 2'd1 : 2'd0;
    end
    dec_o.res0.run_last     = (dec_o.count == 2'd1);
    dec_o.res0.message_done = message_end_i && (dec_o.count == 2'd1);
    dec_o.res1.run_last     = 1'b1;
    dec_o.res1.message_done = message_end_i;

    // Return to the start-of-message state, or advance the offset
    if (message_end_i) begin
      dec_o.next.byte_index     = 16'd0;
      dec_o.next.field_begin    = 17'd0;
      dec_o.next.line_number    = 16'd1;
      dec_o.next.last_separator = mfs_pkg::SepNone;
      dec_o.next.escape_pending = 1'b0;
    end else if (state_i.byte_index < mfs_pkg::PosMax) begin
      dec_o.next.byte_index = state_i.byte_index + 16'd1;
    end
  end

endmodule

### rtl/core/mfs_out_buffer.sv
module mfs_out_buffer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mfs_pkg::result_t res0_i,
  input  mfs_pkg::result_t res1_i,
  input  logic [1:0]       count_i,
  output logic             load_ok_o,
  output logic             valid_o,
  input  logic             ready_i,
  output mfs_pkg::result_t head_o
);

  logic [1:0]       cnt_q, cnt_d;
  mfs_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic             pop;

  assign valid_o   = (cnt_q != 2'd0);
  assign head_o    = slot0_q;
  assign pop       = valid_o && ready_i;
  // Take a new item when the buffer is empty or drains in this cycle
  assign load_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  // Load a fresh pair, or shift up after a transfer
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i) begin
      cnt_d   = count_i;
      slot0_d = res0_i;
      slot1_d = res1_i;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("buffer count out of range");
  load_empty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0) || pop) else $error("load over pending result");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 4;

  // One field descriptor as the splitter reports it
  typedef struct {
    logic [15:0] line_no;
    logic [2:0]  sep;
    logic [15:0] start_pos;
    logic [15:0] len;
    logic        run_last;
    logic        msg_done;
  } field_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic        cfg_wr_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Tracking state of the message in progress, mirrored from the splitter
  logic [15:0] msg_offset;
  logic [16:0] field_origin;
  logic [15:0] cur_line;
  logic [2:0]  sep_code;
  logic        esc_armed;
  logic        mask_on = 1'b0;

  field_t      pending_fields[$];
  field_t      head_field;
  logic [7:0]  msg_bytes[$];
  int unsigned send_gap_pct = 30;
  int unsigned stall_pct = 84;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  message_field_splitter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Return the message tracking to line 1, offset 0
  task automatic clear_tracking();
    msg_offset   = 16'd0;
    field_origin = 17'd0;
    cur_line     = 16'd1;
    sep_code     = mfs_pkg::SepNone;
    esc_armed    = 1'b0;
  endtask

  // Descriptor of the current field ending just before end_pos
  function automatic field_t close_field(logic [16:0] end_pos);
    field_t      d;
    logic [16:0] span;
    span = (end_pos > field_origin) ? end_pos - field_origin : 17'd0;
    d.line_no   = cur_line;
    d.sep       = sep_code;
    d.start_pos = field_origin[16] ? 16'hFFFF : field_origin[15:0];
    d.len       = span[16] ? 16'hFFFF : span[15:0];
    d.run_last  = 1'b0;
    d.msg_done  = 1'b0;
    return d;
  endfunction

  // Work out the descriptors one accepted byte produces and queue them
  task automatic split_byte(input logic [7:0] b, input logic last);
    field_t      made[$];
    logic [16:0] idx;
    logic        esc_at_end;
    idx = {1'b0, msg_offset};
    esc_at_end = 1'b0;
    if (esc_armed) begin
      // Escape pair: '=' or '?' closes the field, anything else is skipped
      esc_armed = 1'b0;
      if (b == mfs_pkg::ChEq || b == mfs_pkg::ChQm) begin
        if (idx > 17'd1) made = {made, close_field(idx - 17'd1)};
        sep_code = (b == mfs_pkg::ChEq) ? mfs_pkg::SepEquals : mfs_pkg::SepQuestion;
      end
      field_origin = idx + 17'd1;
    end else if (b == mfs_pkg::ChEsc) begin
      if (last) esc_at_end = 1'b1;
      else esc_armed = 1'b1;
    end else if (!mask_on && (b == mfs_pkg::ChComma || b == mfs_pkg::ChSlash ||
                              b == mfs_pkg::ChNl)) begin
      if (idx > 17'd0) made = {made, close_field(idx)};
      if (b == mfs_pkg::ChNl && cur_line != mfs_pkg::LineMax) cur_line = cur_line + 16'd1;
      field_origin = idx + 17'd1;
      sep_code = (b == mfs_pkg::ChComma) ? mfs_pkg::SepComma :
                 (b == mfs_pkg::ChSlash) ? mfs_pkg::SepSlash : mfs_pkg::SepNewline;
    end
    if (last) begin
      // Flush the open field, or a null field after a final slash
      if (!esc_at_end && (field_origin < idx + 17'd1 || b == mfs_pkg::ChSlash))
        made = {made, close_field(idx + 17'd1)};
      if (made.size() > 0) made[made.size() - 1].msg_done = 1'b1;
      clear_tracking();
    end else if (msg_offset != mfs_pkg::PosMax) begin
      msg_offset = msg_offset + 16'd1;
    end
    if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
    pending_fields = {pending_fields, made};
  endtask

  // Offer one byte, hold it until the transfer, then predict its fields
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    split_byte(b, last);
  endtask

  // Send msg_bytes as one message
  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // Drop valid and let every expected descriptor come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mask(input logic value);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    mask_on = value;
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Score each descriptor transfer against the oldest prediction, then pick the stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_fields.size() == 0) begin
        $error("field descriptor with none expected");
        error_count++;
      end else begin
        head_field = pending_fields.pop_front();
        check_field("field_line", 32'(head_field.line_no), 32'(m_axis_tdata[15:0]));
        check_field("field_separator", 32'(head_field.sep), 32'(m_axis_tdata[18:16]));
        check_field("field_start", 32'(head_field.start_pos), 32'(m_axis_tdata[34:19]));
        check_field("field_length", 32'(head_field.len), 32'(m_axis_tdata[50:35]));
        check_field("run_last", 32'(head_field.run_last), 32'(m_axis_tlast));
        check_field("message_done", 32'(head_field.msg_done), 32'(m_axis_tuser));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Separators, escapes, byte extremes and message edges with masking off
  task automatic test_plain_fields();
    set_mask(1'b0);
    msg_bytes = '{mfs_pkg::ChComma, 8'h61, mfs_pkg::ChEsc, mfs_pkg::ChEq, 8'h62,
                  mfs_pkg::ChEsc, 8'h78, 8'h63, mfs_pkg::ChNl, 8'h00, 8'hFF,
                  mfs_pkg::ChSlash};
    send_message();
    // Escape pair at the start, lone escape as last byte
    msg_bytes = '{mfs_pkg::ChEsc, mfs_pkg::ChQm, 8'h64, mfs_pkg::ChEsc};
    send_message();
    // Escaped slash as last byte
    msg_bytes = '{mfs_pkg::ChEsc, mfs_pkg::ChSlash};
    send_message();
    msg_bytes = '{mfs_pkg::ChSlash};
    send_message();
    msg_bytes = '{8'h71};
    send_message();
    msg_bytes = '{8'h41, mfs_pkg::ChNl, mfs_pkg::ChNl, 8'h42};
    send_message();
  endtask

  // Comma, slash and newline pass through as data; escapes still split
  task automatic test_mask_mode();
    set_mask(1'b1);
    msg_bytes = '{8'h61, mfs_pkg::ChComma, mfs_pkg::ChSlash, mfs_pkg::ChNl,
                  mfs_pkg::ChEsc, mfs_pkg::ChEq, 8'h62};
    send_message();
    msg_bytes = '{mfs_pkg::ChComma};
    send_message();
  endtask

  // Mostly short messages rich in separators and escape pairs
  task automatic send_random_messages(input int unsigned n_items);
    int unsigned sent;
    int unsigned msg_len;
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  prev;
    sent = 0;
    while (sent < n_items) begin
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
      prev = 8'h00;
      for (int unsigned k = 0; k < msg_len; k++) begin
        pick = $urandom_range(99);
        if (prev == mfs_pkg::ChEsc && pick < 50) b = (pick < 25) ? mfs_pkg::ChEq : mfs_pkg::ChQm;
        else if (pick < 12) b = mfs_pkg::ChComma;
        else if (pick < 22) b = mfs_pkg::ChSlash;
        else if (pick < 32) b = mfs_pkg::ChNl;
        else if (pick < 45) b = mfs_pkg::ChEsc;
        else if (pick < 52) b = mfs_pkg::ChEq;
        else if (pick < 58) b = mfs_pkg::ChQm;
        else b = 8'($urandom_range(255));
        send_byte(b, k == msg_len - 1);
        prev = b;
        sent++;
      end
    end
  endtask

  // Random traffic across the idle patterns, both mask settings in each
  task automatic test_random_traffic();
    int unsigned gap_pcts[3] = '{30, 84, 0};
    int unsigned stall_pcts[3] = '{84, 30, 0};
    for (int p = 0; p < 3; p++) begin
      for (int m = 0; m < 2; m++) begin
        set_mask(m[0]);
        send_gap_pct = gap_pcts[p];
        stall_pct    = stall_pcts[p];
        send_random_messages(176);
      end
    end
  endtask

  // One long message: many lines, then a long field closed by the last byte
  task automatic test_long_message();
    set_mask(1'b0);
    send_gap_pct = 0;
    stall_pct    = 0;
    for (int unsigned k = 0; k < 24; k++) send_byte(mfs_pkg::ChNl, 1'b0);
    for (int unsigned k = 0; k < 16; k++) send_byte(8'h41, k == 15);
  endtask

  initial begin
    clear_tracking();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_fields();
    test_mask_mode();
    test_random_traffic();
    test_long_message();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/mfs_pkg.sv
rtl/core/mfs_field_decode.sv
rtl/core/mfs_out_buffer.sv
rtl/core/message_field_splitter_unit.sv
tb/sv/tb.sv
